>>> hdl/fcpa_pkg.sv
package fcpa_pkg;

   localparam int MAX_BLOCKS           = 16;
   localparam int MAX_CHUNKS_PER_BLOCK = 64;
   localparam int POOL_DEPTH           = MAX_BLOCKS * MAX_CHUNKS_PER_BLOCK;

   localparam int HANDLE_W = 10;
   localparam int BLK_W    = 4;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 5;
   localparam int CFG_W    = 7;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = HANDLE_W + 1;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 2'd2;

   typedef struct packed {
      logic                none;
      logic [HANDLE_W-1:0] handle;
   } link_type;

endpackage

>>> hdl/fcpa_ram.sv
module fcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fixed_chunk_pool_allocator.sv
// Channel   Direction  Handshake         Payload
// req       in         req_valid/stall   req_type, req_chunk_handle
// rsp       out        rsp_valid/stall   rsp_status, rsp_granted_handle
// csr       in         csr_valid/ready   csr_carve_len
//
// Release and exhausted allocate answer straight from idle. Allocate from a non-empty
// list goes to the pop state, which uses the registered read of the link memory.
// A carving allocate adds one link write per carved chunk, then the read state.
// Reset clears the list head, block count and config; link memory is not cleared.
// A new request is taken only while idle and the result register can be loaded.
module fixed_chunk_pool_allocator
   import fcpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [HANDLE_W-1:0] req_chunk_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HANDLE_W-1:0] rsp_granted_handle,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_carve_len
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CARVE = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_POP   = 2'd3;

   logic [1:0]          state_ff, state_in;
   link_type            head_ff, head_in;
   logic [CNT_W-1:0]    carved_ff, carved_in;
   logic [IDX_W-1:0]    carve_idx_ff, carve_idx_in;
   logic [CFG_W-1:0]    cfg_ff;
   logic [IDX_W-1:0]    block_last_ff [MAX_BLOCKS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;

   logic                accept;
   logic                out_free;
   logic [IDX_W-1:0]    carve_last;
   logic [BLK_W-1:0]    rel_blk;
   logic [IDX_W-1:0]    rel_idx;
   logic                rel_bad;
   logic                ram_wr_en;
   logic [HANDLE_W-1:0] ram_wr_addr;
   link_type            ram_wr_data;
   link_type            ram_rd_data;
   logic                len_wr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (cfg_ff == '0) begin
         carve_last = '0;
      end else if (cfg_ff > CFG_W'(MAX_CHUNKS_PER_BLOCK)) begin
         carve_last = IDX_W'(MAX_CHUNKS_PER_BLOCK - 1);
      end else begin
         carve_last = IDX_W'(cfg_ff - CFG_W'(1));
      end
   end

   assign rel_blk = req_chunk_handle[HANDLE_W-1 -: BLK_W];
   assign rel_idx = req_chunk_handle[IDX_W-1:0];
   assign rel_bad = ({1'b0, rel_blk} >= carved_ff) || (rel_idx > block_last_ff[rel_blk]);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      carved_in     = carved_ff;
      carve_idx_in  = carve_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = req_chunk_handle;
      ram_wr_data   = head_ff;
      len_wr        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_RELEASE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_handle_in = '0;
                  if (rel_bad) begin
                     rsp_status_in = STATUS_BAD_HANDLE;
                  end else begin
                     rsp_status_in = STATUS_OK;
                     ram_wr_en     = 1'b1;
                     head_in       = '{none: 1'b0, handle: req_chunk_handle};
                  end
               end else if (!head_ff.none) begin
                  state_in = ST_POP;
               end else if (carved_ff < CNT_W'(MAX_BLOCKS)) begin
                  state_in     = ST_CARVE;
                  carve_idx_in = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EXHAUSTED;
                  rsp_handle_in = '0;
               end
            end
         end
         ST_CARVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {carved_ff[BLK_W-1:0], carve_idx_ff};
            if (carve_idx_ff == carve_last) begin
               ram_wr_data = head_ff;
               head_in     = '{none: 1'b0, handle: {carved_ff[BLK_W-1:0], {IDX_W{1'b0}}}};
               carved_in   = carved_ff + CNT_W'(1);
               len_wr      = 1'b1;
               state_in    = ST_READ;
            end else begin
               ram_wr_data  = '{none: 1'b0,
                                handle: {carved_ff[BLK_W-1:0], carve_idx_ff + IDX_W'(1)}};
               carve_idx_in = carve_idx_ff + IDX_W'(1);
            end
         end
         ST_READ: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_handle_in = head_ff.handle;
               head_in       = ram_rd_data;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '{none: 1'b1, handle: '0};
         carved_ff    <= '0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         carved_ff    <= carved_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_carve_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      carve_idx_ff  <= carve_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      if (len_wr) begin
         block_last_ff[carved_ff[BLK_W-1:0]] <= carve_last;
      end
   end

   // next-link store, read address follows the list head
   fcpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff.handle),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_handle = rsp_handle_ff;

endmodule
